[rtl/dbst_pkg.sv]
// shared types, constants and the control word merge for the breakpoint slot table
package dbst_pkg;

  localparam int SLOT_COUNT_DEF = 4;
  localparam int SLOT_W = 2;
  localparam int ID_W = 32;
  localparam int ADDR_W = 64;
  localparam int CTRL_W = 64;
  localparam int KIND_W = 2;
  localparam int LEN_W = 2;
  localparam int OP_W = 3;

  // layout of the debug control word
  localparam int CTRL_EN_STRIDE = 2;
  localparam int CTRL_KIND_BASE = 16;
  localparam int CTRL_LEN_BASE = 18;
  localparam int CTRL_FIELD_STRIDE = 4;

  typedef enum logic [OP_W-1:0] {
    OP_ADD        = 3'd0,
    OP_REMOVE     = 3'd1,
    OP_REMOVE_ALL = 3'd2,
    OP_FIND_SLOT  = 3'd3,
    OP_FIND_ID    = 3'd4,
    OP_FIND_ADDR  = 3'd5,
    OP_APPLY      = 3'd6,
    OP_NOP        = 3'd7
  } op_t;

  typedef struct packed {
    logic              free_hit;
    logic [SLOT_W-1:0] free_slot;
    logic              id_hit;
    logic [SLOT_W-1:0] id_slot;
    logic              addr_hit;
    logic [SLOT_W-1:0] addr_slot;
  } match_t;

  // set local enable, kind and length fields of one slot
  function automatic logic [CTRL_W-1:0] merge_ctrl(
    input logic [CTRL_W-1:0] ctrl,
    input logic [SLOT_W-1:0] slot,
    input logic [KIND_W-1:0] kind,
    input logic [LEN_W-1:0]  len
  );
    logic [CTRL_W-1:0] w;
    int                s;
    w = ctrl;
    s = int'(slot);
    w[s * CTRL_EN_STRIDE] = 1'b1;
    w[CTRL_KIND_BASE + s * CTRL_FIELD_STRIDE +: KIND_W] = kind;
    w[CTRL_LEN_BASE + s * CTRL_FIELD_STRIDE +: LEN_W] = len;
    return w;
  endfunction

endpackage

[rtl/dbst_match.sv]
// parallel compare and lowest-slot priority encode over the slot table
module dbst_match #(
  parameter int SLOT_COUNT = dbst_pkg::SLOT_COUNT_DEF
) (
  input  logic                      used [SLOT_COUNT],
  input  logic [dbst_pkg::ID_W-1:0]   idents [SLOT_COUNT],
  input  logic [dbst_pkg::ADDR_W-1:0] addrs [SLOT_COUNT],
  input  logic [dbst_pkg::ID_W-1:0]   ident,
  input  logic [dbst_pkg::ADDR_W-1:0] address,
  output dbst_pkg::match_t          match
);
  import dbst_pkg::*;

  // walk downward so the lowest slot wins
  always_comb begin
    match = '0;
    for (int s = SLOT_COUNT - 1; s >= 0; s--) begin
      if (!used[s]) begin
        match.free_hit  = 1'b1;
        match.free_slot = SLOT_W'(s);
      end
      if (used[s] && idents[s] == ident) begin
        match.id_hit  = 1'b1;
        match.id_slot = SLOT_W'(s);
      end
      if (used[s] && addrs[s] == address) begin
        match.addr_hit  = 1'b1;
        match.addr_slot = SLOT_W'(s);
      end
    end
  end

endmodule

[rtl/debug_breakpoint_slot_table.sv]
// top level of the hardware breakpoint slot table
//
// Requests enter on start while busy is low; one request is taken per cycle.
// Add, remove, remove all and the three lookups give one result on the
// cycle after the request, with last set. Apply gives SLOT_COUNT results,
// one a cycle, lowest slot first, the first one on the cycle after the
// request; busy stays high until the last of the SLOT_COUNT results is
// shown, so no request is taken meanwhile; other requests leave busy low.
// The apply sequencer (slot counter and running control word) drives busy.
// Each result is shown for one cycle with done high; the receiver cannot
// stall, so results are never held. Slot compares and the priority encode
// of the lowest free or matching slot finish in the request cycle.
// Synchronous reset empties every slot, sets the next identifier to one
// and drops done and busy; the table is usable in the cycle after reset.
module debug_breakpoint_slot_table #(
  parameter int SLOT_COUNT = dbst_pkg::SLOT_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [dbst_pkg::OP_W-1:0]     operation,
  input  logic [dbst_pkg::ADDR_W-1:0]   address,
  input  logic [dbst_pkg::KIND_W-1:0]   kind,
  input  logic [dbst_pkg::LEN_W-1:0]    length_code,
  input  logic [dbst_pkg::ID_W-1:0]     ident,
  input  logic [dbst_pkg::SLOT_W-1:0]   slot_index,
  input  logic [dbst_pkg::CTRL_W-1:0]   context_control,
  output logic                          done,
  output logic                          ok,
  output logic [dbst_pkg::ID_W-1:0]     result_ident,
  output logic [dbst_pkg::ADDR_W-1:0]   result_address,
  output logic [dbst_pkg::KIND_W-1:0]   result_kind,
  output logic [dbst_pkg::LEN_W-1:0]    result_length,
  output logic [dbst_pkg::SLOT_W-1:0]   result_slot,
  output logic                          write_address,
  output logic [dbst_pkg::CTRL_W-1:0]   control_word,
  output logic                          last
);
  import dbst_pkg::*;

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  logic              slot_used [SLOT_COUNT];
  logic [ID_W-1:0]   slot_ident [SLOT_COUNT];
  logic [ADDR_W-1:0] slot_address [SLOT_COUNT];
  logic [KIND_W-1:0] slot_kind [SLOT_COUNT];
  logic [LEN_W-1:0]  slot_length [SLOT_COUNT];
  logic [ID_W-1:0]   next_ident;

  logic              slot_used_next [SLOT_COUNT];
  logic [ID_W-1:0]   next_ident_next;
  logic              wr_en;
  logic [SLOT_W-1:0] wr_slot;

  logic              apply_active;
  logic [IDX_W-1:0]  apply_slot;
  logic [CTRL_W-1:0] apply_ctrl;

  match_t            match;
  logic              accept;
  op_t               op;

  // selected entry for results
  logic              sel_hit;
  logic [SLOT_W-1:0] sel_slot;
  logic              sel_used;
  logic [ID_W-1:0]   sel_ident;
  logic [ADDR_W-1:0] sel_addr;
  logic [KIND_W-1:0] sel_kind;
  logic [LEN_W-1:0]  sel_len;

  // next result
  logic              ok_next;
  logic [ID_W-1:0]   ident_next;
  logic [ADDR_W-1:0] addr_next;
  logic [KIND_W-1:0] kind_next;
  logic [LEN_W-1:0]  len_next;
  logic [SLOT_W-1:0] slot_next;
  logic              waddr_next;
  logic [CTRL_W-1:0] ctrl_next;
  logic              last_next;
  logic [CTRL_W-1:0] ctrl_in;

  dbst_match #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_match (
    .used    (slot_used),
    .idents  (slot_ident),
    .addrs   (slot_address),
    .ident   (ident),
    .address (address),
    .match   (match)
  );

  assign busy   = apply_active;
  assign accept = start && !busy;
  assign op     = op_t'(operation);

  // which slot the result reads from
  always_comb begin
    sel_hit  = 1'b0;
    sel_slot = '0;
    if (apply_active) begin
      sel_hit  = 1'b1;
      sel_slot = SLOT_W'(apply_slot);
    end else begin
      unique case (op)
        OP_FIND_SLOT: begin
          sel_hit  = 1'b1;
          sel_slot = slot_index;
        end
        OP_FIND_ID: begin
          sel_hit  = match.id_hit;
          sel_slot = match.id_slot;
        end
        OP_FIND_ADDR: begin
          sel_hit  = match.addr_hit;
          sel_slot = match.addr_slot;
        end
        OP_APPLY: begin
          sel_hit  = 1'b1;
          sel_slot = '0;
        end
        default: begin
          sel_hit  = 1'b0;
          sel_slot = '0;
        end
      endcase
    end
  end

  // slot index beyond the table reads as unused
  always_comb begin
    sel_used  = 1'b0;
    sel_ident = '0;
    sel_addr  = '0;
    sel_kind  = '0;
    sel_len   = '0;
    for (int s = 0; s < SLOT_COUNT; s++) begin
      if (sel_slot == SLOT_W'(s)) begin
        sel_used  = slot_used[s];
        sel_ident = slot_ident[s];
        sel_addr  = slot_address[s];
        sel_kind  = slot_kind[s];
        sel_len   = slot_length[s];
      end
    end
  end

  always_comb begin
    ok_next         = 1'b0;
    ident_next      = '0;
    addr_next       = '0;
    kind_next       = '0;
    len_next        = '0;
    slot_next       = '0;
    waddr_next      = 1'b0;
    ctrl_next       = '0;
    last_next       = 1'b1;
    next_ident_next = next_ident;
    wr_en           = 1'b0;
    wr_slot         = match.free_slot;
    ctrl_in         = apply_active ? apply_ctrl : context_control;
    for (int s = 0; s < SLOT_COUNT; s++) begin
      slot_used_next[s] = slot_used[s];
    end

    if (apply_active || op == OP_APPLY) begin
      slot_next = sel_slot;
      ctrl_next = ctrl_in;
      last_next = (sel_slot == SLOT_W'(SLOT_COUNT - 1));
      if (sel_used) begin
        ok_next    = 1'b1;
        ident_next = sel_ident;
        addr_next  = sel_addr;
        kind_next  = sel_kind;
        len_next   = sel_len;
        waddr_next = 1'b1;
        ctrl_next  = merge_ctrl(ctrl_in, sel_slot, sel_kind, sel_len);
      end
    end else begin
      unique case (op)
        OP_ADD: begin
          if (match.free_hit) begin
            wr_en      = 1'b1;
            ok_next    = 1'b1;
            ident_next = next_ident;
            addr_next  = address;
            kind_next  = kind;
            len_next   = length_code;
            slot_next  = match.free_slot;
            // zero is never handed out
            next_ident_next = (next_ident == '1) ? ID_W'(1) : next_ident + ID_W'(1);
            for (int s = 0; s < SLOT_COUNT; s++) begin
              if (match.free_slot == SLOT_W'(s)) slot_used_next[s] = 1'b1;
            end
          end
        end
        OP_REMOVE: begin
          if (match.id_hit) begin
            ok_next    = 1'b1;
            ident_next = ident;
            slot_next  = match.id_slot;
            for (int s = 0; s < SLOT_COUNT; s++) begin
              if (match.id_slot == SLOT_W'(s)) slot_used_next[s] = 1'b0;
            end
          end
        end
        OP_REMOVE_ALL: begin
          ok_next = 1'b1;
          for (int s = 0; s < SLOT_COUNT; s++) begin
            slot_used_next[s] = 1'b0;
          end
        end
        OP_FIND_SLOT, OP_FIND_ID, OP_FIND_ADDR: begin
          if (sel_hit && sel_used) begin
            ok_next    = 1'b1;
            ident_next = sel_ident;
            addr_next  = sel_addr;
            kind_next  = sel_kind;
            len_next   = sel_len;
            slot_next  = sel_slot;
          end
        end
        default: begin
          ok_next = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done         <= 1'b0;
      apply_active <= 1'b0;
      apply_slot   <= '0;
      next_ident   <= ID_W'(1);
      for (int s = 0; s < SLOT_COUNT; s++) begin
        slot_used[s] <= 1'b0;
      end
    end else begin
      done <= accept || apply_active;
      if (accept || apply_active) begin
        ok             <= ok_next;
        result_ident   <= ident_next;
        result_address <= addr_next;
        result_kind    <= kind_next;
        result_length  <= len_next;
        result_slot    <= slot_next;
        write_address  <= waddr_next;
        control_word   <= ctrl_next;
        last           <= last_next;
      end
      if (accept) begin
        next_ident <= next_ident_next;
        for (int s = 0; s < SLOT_COUNT; s++) begin
          slot_used[s] <= slot_used_next[s];
        end
      end
      // apply sequencer: slot 0 goes out with the request, the rest follow
      if (accept && op == OP_APPLY) begin
        apply_active <= (SLOT_COUNT > 1);
        apply_slot   <= IDX_W'(1);
        apply_ctrl   <= ctrl_next;
      end else if (apply_active) begin
        apply_ctrl <= ctrl_next;
        apply_slot <= apply_slot + IDX_W'(1);
        if (last_next) apply_active <= 1'b0;
      end
    end
  end

  // payload stores only change on add; stale fields sit behind slot_used
  always_ff @(posedge clk) begin
    if (accept && wr_en) begin
      for (int s = 0; s < SLOT_COUNT; s++) begin
        if (wr_slot == SLOT_W'(s)) begin
          slot_ident[s]   <= next_ident;
          slot_address[s] <= address;
          slot_kind[s]    <= kind;
          slot_length[s]  <= length_code;
        end
      end
    end
  end

endmodule

[rtl/dbst_checker.sv]
// port-level checks on the result sequence of the breakpoint slot table
module dbst_checker #(
  parameter int SLOT_COUNT = dbst_pkg::SLOT_COUNT_DEF
) (
  input logic                      clk,
  input logic                      rst,
  input logic                      start,
  input logic                      busy,
  input logic [dbst_pkg::OP_W-1:0] operation,
  input logic                      done,
  input logic                      last
);
  import dbst_pkg::*;

  // a result only follows a taken request or an apply in progress
  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy) || $past(busy))
    else $error("result without request");

  // during apply every cycle carries a result, and only the final one is last
  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> (last == !busy))
    else $error("last does not match busy");

  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    busy |-> done)
    else $error("busy cycle without result");

  // a multi-slot apply holds off the next request
  a_apply_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && operation == OP_APPLY && SLOT_COUNT > 1) |=> busy)
    else $error("apply did not raise busy");

endmodule

bind debug_breakpoint_slot_table dbst_checker #(
  .SLOT_COUNT (SLOT_COUNT)
) u_dbst_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .operation (operation),
  .done      (done),
  .last      (last)
);
